FILE: rtl/core/drr_pkg.sv
// ----------------------------------------------------------------------------
// drr_pkg
// Shared types and constants of the set-dueling re-reference replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package drr_pkg;

	localparam int SETS        = 1024;
	localparam int WAYS        = 16;
	localparam int RRPV_BITS   = 2;
	localparam int SEL_W       = 10;

	localparam int SET_BITS    = $clog2(SETS);
	localparam int WAY_BITS    = $clog2(WAYS);
	localparam int RRPV_LEVELS = 2 ** RRPV_BITS;

	localparam int OP_W        = 2;
	localparam int SET_IDX_W   = 10;
	localparam int WAY_IDX_W   = 4;
	localparam int DRAW_W      = 7;
	localparam int POL_W       = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;
	localparam int THR_W       = 7;
	localparam int OFS_W       = 3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [RRPV_BITS-1:0] RRPV_MAX  = '1;
	localparam logic [RRPV_BITS-1:0] RRPV_LONG = RRPV_MAX - RRPV_BITS'(1);
	localparam logic [SEL_W-1:0]     PSEL_MAX  = '1;
	localparam logic [SEL_W-1:0]     PSEL_RESET = {1'b1, {(SEL_W-1){1'b0}}};

	localparam logic             HIT_ZERO_RESET     = 1'b1;
	localparam logic [THR_W-1:0] THRESHOLD_RESET    = 7'd3;
	localparam logic [OFS_W-1:0] OFFSET_BITS_RESET  = 3'd5;

	typedef enum logic [OP_W-1:0] {
		OP_TOUCH  = 2'd0,
		OP_INVAL  = 2'd1,
		OP_FILL   = 2'd2,
		OP_VICTIM = 2'd3
	} op_t;

	typedef enum logic [POL_W-1:0] {
		POL_NONE    = 2'd0,
		POL_BIMODAL = 2'd1,
		POL_STATIC  = 2'd2
	} pol_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HIT_ZERO           = 2'd0,
		CFG_BIMODAL_THRESHOLD  = 2'd1,
		CFG_SAMPLE_OFFSET_BITS = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_READ,
		B_EXEC
	} back_state_t;

	typedef struct packed {
		logic             hit_zero;
		logic [THR_W-1:0] bimodal_threshold;
		logic [OFS_W-1:0] sample_offset_bits;
	} cfg_t;

	typedef struct packed {
		op_t                  op;
		logic [SET_IDX_W-1:0] set_idx;
		logic [WAY_IDX_W-1:0] way_idx;
		logic [DRAW_W-1:0]    draw;
		logic                 way_ok;
		logic                 lead_bimodal;
		logic                 lead_static;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} queue_head_t;

	typedef struct packed {
		logic clear_done;
		logic pop;
	} back_stat_t;

	typedef struct packed {
		logic [WAYS-1:0]                valid;
		logic [WAYS-1:0][RRPV_BITS-1:0] rrpv;
	} row_t;

endpackage

`default_nettype wire

FILE: rtl/core/drr_if.sv
// ----------------------------------------------------------------------------
// drr_if
// Request, response and register write channels of the replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

interface drr_req_if;
	logic                           valid;
	logic                           ready;
	logic [drr_pkg::OP_W-1:0]       operation;
	logic [drr_pkg::SET_IDX_W-1:0]  set_index;
	logic [drr_pkg::WAY_IDX_W-1:0]  way_index;
	logic [drr_pkg::DRAW_W-1:0]     random_draw;

	modport source (output valid, operation, set_index, way_index, random_draw, input ready);
	modport sink   (input valid, operation, set_index, way_index, random_draw, output ready);
endinterface

interface drr_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [drr_pkg::WAY_IDX_W-1:0]  victim_way;
	logic                           victim_was_invalid;
	logic [drr_pkg::POL_W-1:0]      insert_policy;
	logic [drr_pkg::SEL_W-1:0]      selector_value;

	modport source (output valid, victim_way, victim_was_invalid, insert_policy,
		selector_value, input ready);
	modport sink   (input valid, victim_way, victim_was_invalid, insert_policy,
		selector_value, output ready);
endinterface

interface drr_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [drr_pkg::CFG_IDX_W-1:0]   index;
	logic [drr_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/drr_front.sv
// ----------------------------------------------------------------------------
// drr_front
// Request intake: classifies each request (leader set kind, way range) and
// holds it in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_front (
	input  wire                       clk,
	input  wire                       arst_n,
	drr_req_if.sink                   req,
	input  drr_pkg::cfg_t             cfg,
	input  drr_pkg::back_stat_t       stat,
	output drr_pkg::queue_head_t      head
);

	drr_pkg::req_t                     q_q [drr_pkg::QUEUE_DEPTH];
	logic [drr_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [drr_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [drr_pkg::QCNT_W-1:0]        cnt_q;
	logic                              push;
	logic                              pop;
	logic [drr_pkg::SET_IDX_W-1:0]     mask;
	logic [drr_pkg::SET_IDX_W-1:0]     lo;
	logic [drr_pkg::SET_IDX_W-1:0]     hi;
	drr_pkg::req_t                     cls;

	assign req.ready = stat.clear_done && (cnt_q != drr_pkg::QCNT_W'(drr_pkg::QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign pop       = stat.pop;

	always_comb begin
		mask = ~({drr_pkg::SET_IDX_W{1'b1}} << cfg.sample_offset_bits);
		lo   = req.set_index & mask;
		hi   = (req.set_index >> cfg.sample_offset_bits) & mask;
		cls.op           = drr_pkg::op_t'(req.operation);
		cls.set_idx      = req.set_index;
		cls.way_idx      = req.way_index;
		cls.draw         = req.random_draw;
		cls.way_ok       = {1'b0, req.way_index} < (drr_pkg::WAY_IDX_W + 1)'(drr_pkg::WAYS);
		cls.lead_bimodal = (lo == hi);
		cls.lead_static  = (lo == (~hi & mask));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + drr_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + drr_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + drr_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - drr_pkg::QCNT_W'(1);
			end
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.req   = q_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: rtl/core/drr_back.sv
// ----------------------------------------------------------------------------
// drr_back
// Execution: clears the valid marks after reset, then reads a set's row,
// applies the request, writes the row back and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_back (
	input  wire                       clk,
	input  wire                       arst_n,
	input  drr_pkg::cfg_t             cfg,
	input  drr_pkg::queue_head_t      head,
	output drr_pkg::back_stat_t       stat,
	drr_rsp_if.source                 rsp
);

	drr_pkg::row_t                       mem [drr_pkg::SETS];
	drr_pkg::row_t                       rd_row_q;
	drr_pkg::req_t                       cur_q;
	drr_pkg::back_state_t                state_q;
	drr_pkg::back_state_t                state_d;
	logic [drr_pkg::SET_BITS-1:0]        clr_cnt_q;
	logic [drr_pkg::SEL_W-1:0]           sel_q;

	logic                                out_valid_q;
	logic [drr_pkg::WAY_IDX_W-1:0]       out_way_q;
	logic                                out_inv_q;
	drr_pkg::pol_t                       out_pol_q;
	logic [drr_pkg::SEL_W-1:0]           out_sel_q;

	logic                                out_free;
	logic                                pop;
	logic                                rd_en;
	logic                                we;
	logic                                out_load;
	logic [drr_pkg::SET_BITS-1:0]        waddr;
	drr_pkg::row_t                       wdata;

	drr_pkg::row_t                       new_row;
	logic [drr_pkg::SEL_W-1:0]           sel_new;
	logic [drr_pkg::WAY_IDX_W-1:0]       res_way;
	logic                                res_inv;
	drr_pkg::pol_t                       res_pol;

	logic                                found_inv;
	logic [drr_pkg::WAY_BITS-1:0]        inv_way;
	logic [drr_pkg::RRPV_LEVELS-1:0]     lvl_hit;
	logic [drr_pkg::RRPV_BITS-1:0]       max_v;
	logic [drr_pkg::WAY_BITS-1:0]        max_way;
	logic [drr_pkg::RRPV_BITS-1:0]       gap;
	logic [drr_pkg::RRPV_BITS:0]         sum;
	logic [drr_pkg::WAY_BITS-1:0]        way;
	logic [drr_pkg::RRPV_BITS-1:0]       cur_v;

	assign out_free        = !out_valid_q || rsp.ready;
	assign stat.clear_done = (state_q != drr_pkg::B_CLEAR);
	assign stat.pop        = pop;

	// victim search and aging
	always_comb begin
		found_inv = 1'b0;
		inv_way   = '0;
		lvl_hit   = '0;
		max_v     = '0;
		max_way   = '0;
		for (int w = drr_pkg::WAYS - 1; w >= 0; w--) begin
			if (!rd_row_q.valid[w]) begin
				found_inv = 1'b1;
				inv_way   = drr_pkg::WAY_BITS'(w);
			end
		end
		for (int k = 0; k < drr_pkg::RRPV_LEVELS; k++) begin
			for (int w = 0; w < drr_pkg::WAYS; w++) begin
				if (rd_row_q.rrpv[w] == drr_pkg::RRPV_BITS'(k)) begin
					lvl_hit[k] = 1'b1;
				end
			end
		end
		for (int k = 0; k < drr_pkg::RRPV_LEVELS; k++) begin
			if (lvl_hit[k]) begin
				max_v = drr_pkg::RRPV_BITS'(k);
			end
		end
		for (int w = drr_pkg::WAYS - 1; w >= 0; w--) begin
			if (rd_row_q.rrpv[w] == max_v) begin
				max_way = drr_pkg::WAY_BITS'(w);
			end
		end
		gap = drr_pkg::RRPV_MAX - max_v;
	end

	// apply the request to the row and selector
	always_comb begin
		new_row = rd_row_q;
		sel_new = sel_q;
		res_way = '0;
		res_inv = 1'b0;
		res_pol = drr_pkg::POL_NONE;
		sum     = '0;
		way     = cur_q.way_idx[drr_pkg::WAY_BITS-1:0];
		cur_v   = rd_row_q.rrpv[way];
		case (cur_q.op)
			drr_pkg::OP_VICTIM: begin
				if (found_inv) begin
					res_way = drr_pkg::WAY_IDX_W'(inv_way);
					res_inv = 1'b1;
				end else begin
					res_way = drr_pkg::WAY_IDX_W'(max_way);
					for (int w = 0; w < drr_pkg::WAYS; w++) begin
						sum = {1'b0, rd_row_q.rrpv[w]} + {1'b0, gap};
						new_row.rrpv[w] = (sum > {1'b0, drr_pkg::RRPV_MAX}) ?
							drr_pkg::RRPV_MAX : sum[drr_pkg::RRPV_BITS-1:0];
					end
				end
			end
			drr_pkg::OP_TOUCH: begin
				if (cur_q.way_ok) begin
					if (cfg.hit_zero) begin
						new_row.rrpv[way] = '0;
					end else if (cur_v != '0) begin
						new_row.rrpv[way] = cur_v - drr_pkg::RRPV_BITS'(1);
					end
				end
			end
			drr_pkg::OP_INVAL: begin
				if (cur_q.way_ok) begin
					new_row.valid[way] = 1'b0;
				end
			end
			drr_pkg::OP_FILL: begin
				if (cur_q.way_ok) begin
					if (cur_q.lead_bimodal) begin
						res_pol = drr_pkg::POL_BIMODAL;
						if (sel_q != drr_pkg::PSEL_MAX) begin
							sel_new = sel_q + drr_pkg::SEL_W'(1);
						end
					end else if (cur_q.lead_static) begin
						res_pol = drr_pkg::POL_STATIC;
						if (sel_q != '0) begin
							sel_new = sel_q - drr_pkg::SEL_W'(1);
						end
					end else begin
						res_pol = sel_q[drr_pkg::SEL_W-1] ?
							drr_pkg::POL_STATIC : drr_pkg::POL_BIMODAL;
					end
					if (res_pol == drr_pkg::POL_BIMODAL &&
						cur_q.draw > cfg.bimodal_threshold) begin
						new_row.rrpv[way] = drr_pkg::RRPV_MAX;
					end else begin
						new_row.rrpv[way] = drr_pkg::RRPV_LONG;
					end
					new_row.valid[way] = 1'b1;
				end
			end
			default: begin
				new_row = rd_row_q;
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		rd_en    = 1'b0;
		we       = 1'b0;
		out_load = 1'b0;
		waddr    = cur_q.set_idx[drr_pkg::SET_BITS-1:0];
		wdata    = new_row;
		case (state_q)
			drr_pkg::B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_cnt_q;
				wdata = '0;
				if (clr_cnt_q == drr_pkg::SET_BITS'(drr_pkg::SETS - 1)) begin
					state_d = drr_pkg::B_READ;
				end
			end
			drr_pkg::B_READ: begin
				if (head.valid) begin
					pop     = 1'b1;
					rd_en   = 1'b1;
					state_d = drr_pkg::B_EXEC;
				end
			end
			drr_pkg::B_EXEC: begin
				if (out_free) begin
					we       = 1'b1;
					out_load = 1'b1;
					state_d  = drr_pkg::B_READ;
				end
			end
			default: begin
				state_d = drr_pkg::B_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_row_q <= mem[head.req.set_idx[drr_pkg::SET_BITS-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.req;
		end
		if (out_load) begin
			out_way_q <= res_way;
			out_inv_q <= res_inv;
			out_pol_q <= res_pol;
			out_sel_q <= sel_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drr_pkg::B_CLEAR;
			clr_cnt_q   <= '0;
			sel_q       <= drr_pkg::PSEL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == drr_pkg::B_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + drr_pkg::SET_BITS'(1);
			end
			if (out_load) begin
				sel_q       <= sel_new;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.victim_way         = out_way_q;
	assign rsp.victim_was_invalid = out_inv_q;
	assign rsp.insert_policy      = out_pol_q;
	assign rsp.selector_value     = out_sel_q;

endmodule

`default_nettype wire

FILE: rtl/core/drrip_set_dueling_replacement.sv
// ----------------------------------------------------------------------------
// drrip_set_dueling_replacement
// Re-reference prediction replacement with set dueling between bimodal and
// static insertion: register file, request front end and execution back end.
//
//   channel | dir | payload                                            | accept
//   req     | in  | operation, set_index, way_index, random_draw       | valid & ready
//   rsp     | out | victim_way, victim_was_invalid, insert_policy,     | valid & ready
//           |     | selector_value                                     |
//   cfg     | in  | index, data                                        | valid & ready
//
// Each request passes through the back end as a row read of the set memory,
// then modify, write back and load of the response register.
// After reset a pass over all 1024 sets clears the valid marks; req.ready is low
// meanwhile, cfg is always ready. A two-entry queue separates intake from
// execution; a stalled rsp holds the back end, the queue takes requests until full.
// ----------------------------------------------------------------------------
`default_nettype none

module drrip_set_dueling_replacement (
	input  wire          clk,
	input  wire          arst_n,
	drr_req_if.sink      req,
	drr_rsp_if.source    rsp,
	drr_cfg_if.sink      cfg
);

	drr_pkg::cfg_t         cfg_q;
	drr_pkg::queue_head_t  head;
	drr_pkg::back_stat_t   stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hit_zero           <= drr_pkg::HIT_ZERO_RESET;
			cfg_q.bimodal_threshold  <= drr_pkg::THRESHOLD_RESET;
			cfg_q.sample_offset_bits <= drr_pkg::OFFSET_BITS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				drr_pkg::CFG_HIT_ZERO: begin
					cfg_q.hit_zero <= cfg.data[0];
				end
				drr_pkg::CFG_BIMODAL_THRESHOLD: begin
					cfg_q.bimodal_threshold <= cfg.data[drr_pkg::THR_W-1:0];
				end
				drr_pkg::CFG_SAMPLE_OFFSET_BITS: begin
					cfg_q.sample_offset_bits <= cfg.data[drr_pkg::OFS_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	drr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg_q),
		.stat   (stat),
		.head   (head)
	);

	drr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

FILE: rtl/core/drr_checker.sv
// ----------------------------------------------------------------------------
// drr_checker
// Port-level checks of the replacement block's responses.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_checker (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  rsp_valid,
	input  wire                                  rsp_ready,
	input  wire [drr_pkg::WAY_IDX_W-1:0]         rsp_victim_way,
	input  wire                                  rsp_victim_was_invalid,
	input  wire [drr_pkg::POL_W-1:0]             rsp_insert_policy,
	input  wire [drr_pkg::SEL_W-1:0]             rsp_selector_value
);

	logic [drr_pkg::SEL_W-1:0] last_sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sel_q <= drr_pkg::PSEL_RESET;
		end else if (rsp_valid && rsp_ready) begin
			last_sel_q <= rsp_selector_value;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_victim_way) &&
		$stable(rsp_victim_was_invalid) && $stable(rsp_insert_policy) &&
		$stable(rsp_selector_value))
		else $error("response changed while stalled");

	a_policy_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_insert_policy == drr_pkg::POL_NONE) ||
		(rsp_insert_policy == drr_pkg::POL_BIMODAL) ||
		(rsp_insert_policy == drr_pkg::POL_STATIC))
		else $error("undefined insertion policy code");

	a_victim_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_victim_was_invalid || rsp_victim_way != '0) |->
		rsp_insert_policy == drr_pkg::POL_NONE)
		else $error("victim result together with an insertion");

	a_sel_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |->
		(rsp_selector_value == last_sel_q) ||
		(rsp_selector_value == last_sel_q + drr_pkg::SEL_W'(1)) ||
		(rsp_selector_value + drr_pkg::SEL_W'(1) == last_sel_q))
		else $error("selector moved by more than one between responses");

endmodule

bind drrip_set_dueling_replacement drr_checker u_drr_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.rsp_valid              (rsp.valid),
	.rsp_ready              (rsp.ready),
	.rsp_victim_way         (rsp.victim_way),
	.rsp_victim_was_invalid (rsp.victim_was_invalid),
	.rsp_insert_policy      (rsp.insert_policy),
	.rsp_selector_value     (rsp.selector_value)
);

`default_nettype wire
